// ===== rtl/urrf_pkg.sv =====
// shared constants, types and index helpers for the uart receive ring buffer
// no dependencies; used through scoped names by every rtl file except urrf_ram
package urrf_pkg;

  // ring geometry
  localparam int DEPTH     = 256;
  localparam int WATERMARK = 128;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] WM_STEP  = IDX_W'(WATERMARK % DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W+1)'(DEPTH);

  // item modes
  localparam logic [1:0] MODE_RX       = 2'd0;
  localparam logic [1:0] MODE_POP      = 2'd1;
  localparam logic [1:0] MODE_WR_LOW   = 2'd2;
  localparam logic [1:0] MODE_WR_OVFL  = 2'd3;

  // status bits
  localparam logic [2:0] STAT_NONE     = 3'b000;
  localparam logic [2:0] STAT_FRAME    = 3'b001;
  localparam logic [2:0] STAT_OVERRUN  = 3'b010;
  localparam logic [2:0] STAT_BUF_OVFL = 3'b100;

  // registered input beat
  typedef struct packed {
    logic       valid;
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic       frame_error;
    logic       overrun_error;
    logic       flag_value;
  } item_t;

  // registered result, data byte comes from the ram read port
  typedef struct packed {
    logic       done;
    logic       pop_ok;
    logic [2:0] status;
    logic       no_data;
    logic [7:0] fill;
    logic       low_water;
    logic       overflowed;
  } result_t;

  // index plus one, modulo depth
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    if (idx == LAST_IDX) r = '0;
    else r = idx + 1'b1;
    return r;
  endfunction

  // sum of two indices modulo depth, both below depth
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_EXT) s = s - DEPTH_EXT;
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/urrf_in_reg.sv =====
// input register of the receive ring buffer: captures one beat per cycle
// depends on urrf_pkg for the item type
module urrf_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [1:0]        mode,
  input  logic [7:0]        rx_byte,
  input  logic              frame_error,
  input  logic              overrun_error,
  input  logic              flag_value,
  output urrf_pkg::item_t   item
);

  // valid is control, payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      item.valid <= take;
    end
    if (take) begin
      item.mode          <= mode;
      item.rx_byte       <= rx_byte;
      item.frame_error   <= frame_error;
      item.overrun_error <= overrun_error;
      item.flag_value    <= flag_value;
    end
  end

endmodule

// ===== rtl/urrf_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies
module urrf_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/urrf_ctrl.sv =====
// index, status and flag logic of the receive ring buffer with result register
// depends on urrf_pkg; drives the write and read ports of urrf_ram
module urrf_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  urrf_pkg::item_t             item,
  output logic                        mem_we,
  output logic [urrf_pkg::IDX_W-1:0]  mem_waddr,
  output logic                        mem_re,
  output logic [urrf_pkg::IDX_W-1:0]  mem_raddr,
  output urrf_pkg::result_t           res
);

  logic [urrf_pkg::IDX_W-1:0] head_index, head_index_next;
  logic [urrf_pkg::IDX_W-1:0] tail_index, tail_index_next;
  logic [2:0]                 last_status, last_status_next;
  logic                       low_water, low_water_next;
  logic                       overflowed, overflowed_next;
  logic [urrf_pkg::IDX_W-1:0] nh;
  logic [urrf_pkg::IDX_W-1:0] nt;
  logic [urrf_pkg::IDX_W-1:0] fill_idx;
  logic                       empty;
  logic                       full;
  logic                       pop_ok;
  logic                       no_data;

  // next indices and full / empty tests
  always_comb begin
    nh    = urrf_pkg::wrap_inc(head_index);
    nt    = urrf_pkg::wrap_inc(tail_index);
    empty = (head_index == tail_index);
    full  = (nh == tail_index);
  end

  // state update for one beat
  always_comb begin
    head_index_next  = head_index;
    tail_index_next  = tail_index;
    last_status_next = last_status;
    low_water_next   = low_water;
    overflowed_next  = overflowed;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    pop_ok           = 1'b0;
    no_data          = 1'b0;
    if (item.valid) begin
      case (item.mode)
        urrf_pkg::MODE_RX: begin
          if (urrf_pkg::wrap_add(nh, urrf_pkg::WM_STEP) == tail_index) begin
            low_water_next = 1'b0;
          end
          if (full) begin
            last_status_next = urrf_pkg::STAT_BUF_OVFL;
            overflowed_next  = 1'b1;
          end else begin
            head_index_next  = nh;
            mem_we           = 1'b1;
            last_status_next = (item.frame_error ? urrf_pkg::STAT_FRAME : urrf_pkg::STAT_NONE)
                             | (item.overrun_error ? urrf_pkg::STAT_OVERRUN
                                                   : urrf_pkg::STAT_NONE);
          end
        end
        urrf_pkg::MODE_POP: begin
          if (empty) begin
            no_data = 1'b1;
          end else begin
            tail_index_next = nt;
            mem_re          = 1'b1;
            pop_ok          = 1'b1;
            if (urrf_pkg::wrap_inc(nt) == head_index) begin
              low_water_next = 1'b1;
            end
          end
        end
        urrf_pkg::MODE_WR_LOW: begin
          low_water_next = item.flag_value;
        end
        urrf_pkg::MODE_WR_OVFL: begin
          overflowed_next = item.flag_value;
        end
        default: begin
          no_data = 1'b0;
        end
      endcase
    end
  end

  // ram addresses: push writes at the new head, pop reads at the new tail
  assign mem_waddr = nh;
  assign mem_raddr = nt;

  // fill after the step, head minus tail modulo depth
  always_comb begin
    if (head_index_next >= tail_index_next) begin
      fill_idx = head_index_next - tail_index_next;
    end else begin
      fill_idx = urrf_pkg::IDX_W'(urrf_pkg::DEPTH_EXT
                 - {1'b0, tail_index_next} + {1'b0, head_index_next});
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index  <= '0;
      tail_index  <= '0;
      last_status <= urrf_pkg::STAT_NONE;
      low_water   <= 1'b0;
      overflowed  <= 1'b0;
    end else begin
      head_index  <= head_index_next;
      tail_index  <= tail_index_next;
      last_status <= last_status_next;
      low_water   <= low_water_next;
      overflowed  <= overflowed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.done <= 1'b0;
    end else begin
      res.done <= item.valid;
    end
    res.pop_ok     <= pop_ok;
    res.no_data    <= no_data;
    res.status     <= no_data ? urrf_pkg::STAT_NONE : last_status_next;
    res.fill       <= 8'(fill_idx);
    res.low_water  <= low_water_next;
    res.overflowed <= overflowed_next;
  end

endmodule

// ===== rtl/uart_rx_ring_fifo.sv =====
// top level of the uart receive ring buffer: input register, control, byte ram
// depends on urrf_pkg, urrf_in_reg, urrf_ctrl and urrf_ram
//
//  channel   handshake            payload
//  item in   start, busy          mode, rx_byte, frame_error, overrun_error, flag_value
//  result    done (one cycle)     read_byte, read_status, no_data, fill_count,
//                                 low_water_flag, overflowed_flag
//
// one item per cycle; done rises once the beat has passed the input register and the result register
// latency is set by the input register and the registered ram read port
// busy stays low: every beat is finished in the single pass after its register
// rst is synchronous and active high; indices, status and flags clear to zero
// results cannot be stalled and are shown for exactly one cycle
module uart_rx_ring_fifo (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode,
  input  logic [7:0] rx_byte,
  input  logic       frame_error,
  input  logic       overrun_error,
  input  logic       flag_value,
  output logic       done,
  output logic [7:0] read_byte,
  output logic [2:0] read_status,
  output logic       no_data,
  output logic [7:0] fill_count,
  output logic       low_water_flag,
  output logic       overflowed_flag
);

  urrf_pkg::item_t            item;
  urrf_pkg::result_t          res;
  logic                       mem_we;
  logic [urrf_pkg::IDX_W-1:0] mem_waddr;
  logic                       mem_re;
  logic [urrf_pkg::IDX_W-1:0] mem_raddr;
  logic [7:0]                 mem_rdata;

  assign busy = 1'b0;

  // input beat register
  urrf_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .take          (start && !busy),
    .mode          (mode),
    .rx_byte       (rx_byte),
    .frame_error   (frame_error),
    .overrun_error (overrun_error),
    .flag_value    (flag_value),
    .item          (item)
  );

  // indices, flags and result register
  urrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  // byte store
  urrf_ram #(
    .DEPTH (urrf_pkg::DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (item.rx_byte),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result ports
  assign done            = res.done;
  assign read_byte       = res.pop_ok ? mem_rdata : 8'd0;
  assign read_status     = res.status;
  assign no_data         = res.no_data;
  assign fill_count      = res.fill;
  assign low_water_flag  = res.low_water;
  assign overflowed_flag = res.overflowed;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench for uart_rx_ring_fifo: received-byte, pop and flag-write beats against an
// in-bench ring predictor, every result compared field by field
// depends on urrf_pkg and the rtl of uart_rx_ring_fifo
module tb;

  localparam int RING_DEPTH = urrf_pkg::DEPTH;
  localparam int RING_WM    = urrf_pkg::WATERMARK;

  // one expected result beat
  typedef struct packed {
    logic [7:0] rd_byte;
    logic [2:0] status;
    logic       empty;
    logic [7:0] fill;
    logic       low;
    logic       ovfl;
  } ring_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] mode = urrf_pkg::MODE_RX;
  logic [7:0] rx_byte = 8'h00;
  logic       frame_error = 1'b0;
  logic       overrun_error = 1'b0;
  logic       flag_value = 1'b0;
  logic       done;
  logic [7:0] read_byte;
  logic [2:0] read_status;
  logic       no_data;
  logic [7:0] fill_count;
  logic       low_water_flag;
  logic       overflowed_flag;

  // predictor state
  logic [7:0] ring_store [RING_DEPTH];
  int         ring_head = 0;
  int         ring_tail = 0;
  logic [2:0] ring_status = urrf_pkg::STAT_NONE;
  logic       ring_low = 1'b0;
  logic       ring_ovfl = 1'b0;

  ring_result_t pending_results [$];
  int           err_count = 0;
  int           gap_pct = 0;

  uart_rx_ring_fifo u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .rx_byte        (rx_byte),
    .frame_error    (frame_error),
    .overrun_error  (overrun_error),
    .flag_value     (flag_value),
    .done           (done),
    .read_byte      (read_byte),
    .read_status    (read_status),
    .no_data        (no_data),
    .fill_count     (fill_count),
    .low_water_flag (low_water_flag),
    .overflowed_flag(overflowed_flag)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ring behavior for one accepted beat
  function automatic ring_result_t ring_predict(input logic [1:0] m, input logic [7:0] b,
                                                input logic fe, input logic oe,
                                                input logic fv);
    ring_result_t r;
    int           nh;
    logic [2:0]   st;
    r = '0;
    case (m)
      urrf_pkg::MODE_RX: begin
        nh = (ring_head + 1) % RING_DEPTH;
        st = (fe ? urrf_pkg::STAT_FRAME : urrf_pkg::STAT_NONE) |
             (oe ? urrf_pkg::STAT_OVERRUN : urrf_pkg::STAT_NONE);
        // near-full watermark, checked whether the byte is kept or dropped
        if ((nh + RING_WM % RING_DEPTH) % RING_DEPTH == ring_tail) ring_low = 1'b0;
        if (nh == ring_tail) begin
          st = urrf_pkg::STAT_BUF_OVFL;
          ring_ovfl = 1'b1;
        end else begin
          ring_head = nh;
          ring_store[nh] = b;
        end
        ring_status = st;
      end
      urrf_pkg::MODE_POP: begin
        if (ring_head == ring_tail) begin
          r.empty = 1'b1;
        end else begin
          ring_tail = (ring_tail + 1) % RING_DEPTH;
          // one entry left after the pop
          if ((ring_tail + 1) % RING_DEPTH == ring_head) ring_low = 1'b1;
          r.rd_byte = ring_store[ring_tail];
        end
      end
      urrf_pkg::MODE_WR_LOW: ring_low = fv;
      default: ring_ovfl = fv;
    endcase
    r.status = r.empty ? urrf_pkg::STAT_NONE : ring_status;
    r.fill   = 8'((RING_DEPTH + ring_head - ring_tail) % RING_DEPTH);
    r.low    = ring_low;
    r.ovfl   = ring_ovfl;
    return r;
  endfunction

  // drive one beat at the falling edge, hold it until accepted, then predict
  task automatic send_item(input logic [1:0] m, input logic [7:0] b, input logic fe,
                           input logic oe, input logic fv);
    @(negedge clk);
    while ($urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    mode          <= m;
    rx_byte       <= b;
    frame_error   <= fe;
    overrun_error <= oe;
    flag_value    <= fv;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(ring_predict(m, b, fe, oe, fv));
  endtask

  task automatic send_rand(input logic [1:0] m);
    send_item(m, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
              1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
  endtask

  // field compare with report, four-state so unknown bits are caught
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // result checker: every done beat against the oldest expectation
  always @(posedge clk) begin
    ring_result_t e;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual byte %0h fill %0h",
                 $time, read_byte, fill_count);
      end else begin
        e = pending_results.pop_front();
        check_field("read_byte", e.rd_byte, read_byte);
        check_field("read_status", e.status, read_status);
        check_field("no_data", e.empty, no_data);
        check_field("fill_count", e.fill, fill_count);
        check_field("low_water_flag", e.low, low_water_flag);
        check_field("overflowed_flag", e.ovfl, overflowed_flag);
      end
    end
  end

  // field extremes, every mode, empty read and one entry left
  task automatic test_directed();
    gap_pct = 21;
    send_item(urrf_pkg::MODE_POP, 8'hff, 1'b1, 1'b1, 1'b1);
    send_item(urrf_pkg::MODE_WR_LOW, 8'hff, 1'b1, 1'b1, 1'b1);
    send_item(urrf_pkg::MODE_WR_OVFL, 8'h00, 1'b0, 1'b0, 1'b1);
    send_item(urrf_pkg::MODE_RX, 8'h00, 1'b0, 1'b0, 1'b1);
    send_item(urrf_pkg::MODE_RX, 8'hff, 1'b1, 1'b1, 1'b0);
    send_item(urrf_pkg::MODE_RX, 8'ha5, 1'b1, 1'b0, 1'b0);
    send_item(urrf_pkg::MODE_RX, 8'h5a, 1'b0, 1'b1, 1'b1);
    send_item(urrf_pkg::MODE_WR_LOW, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(urrf_pkg::MODE_WR_OVFL, 8'hff, 1'b1, 1'b1, 1'b0);
    send_item(urrf_pkg::MODE_POP, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(urrf_pkg::MODE_POP, 8'hff, 1'b1, 1'b1, 1'b1);
    send_item(urrf_pkg::MODE_POP, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(urrf_pkg::MODE_POP, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(urrf_pkg::MODE_POP, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(urrf_pkg::MODE_RX, 8'h81, 1'b0, 1'b0, 1'b0);
    send_item(urrf_pkg::MODE_POP, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(urrf_pkg::MODE_POP, 8'h00, 1'b0, 1'b0, 1'b0);
  endtask

  // fill to full through the watermark and head wrap, overflow, then drain part way
  task automatic test_fill_drain();
    gap_pct = 21;
    send_rand(urrf_pkg::MODE_RX);
    send_item(urrf_pkg::MODE_WR_LOW, 8'h00, 1'b0, 1'b0, 1'b1);
    while ((RING_DEPTH + ring_head - ring_tail) % RING_DEPTH < RING_DEPTH - 1)
      send_rand(urrf_pkg::MODE_RX);
    repeat (3) send_rand(urrf_pkg::MODE_RX);
    send_item(urrf_pkg::MODE_WR_OVFL, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(urrf_pkg::MODE_WR_LOW, 8'h00, 1'b0, 1'b0, 1'b1);
    send_rand(urrf_pkg::MODE_RX);
    while ((RING_DEPTH + ring_head - ring_tail) % RING_DEPTH > RING_DEPTH - 64)
      send_rand(urrf_pkg::MODE_POP);
  endtask

  // random bursts that lean toward filling or draining the ring
  task automatic test_random(input int n_items, input int gap);
    int burst_left;
    bit fill_bias;
    int pick;
    gap_pct = gap;
    burst_left = 0;
    fill_bias = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(60, 1);
        fill_bias = 1'($urandom_range(1, 0));
      end
      burst_left--;
      pick = $urandom_range(99, 0);
      if (pick < 8) send_rand(urrf_pkg::MODE_WR_LOW);
      else if (pick < 12) send_rand(urrf_pkg::MODE_WR_OVFL);
      else if ((pick < 78) == fill_bias) send_rand(urrf_pkg::MODE_RX);
      else send_rand(urrf_pkg::MODE_POP);
    end
  endtask

  // main sequence
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_drain();
    test_random(40, 21);
    test_random(40, 49);
    test_random(40, 0);
    @(negedge clk);
    start <= 1'b0;
    for (int w = 0; w < 64 && pending_results.size() != 0; w++) @(posedge clk);
    repeat (6) @(posedge clk);
    if (pending_results.size() != 0) begin
      err_count++;
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               pending_results.size());
    end
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("tb: errors");
    $finish;
  end

endmodule
